/* sv/key_value_map_with_id_allocator_unit_assert.svh */
// Assertion macros for the key/value map. Empty in synthesis.
`ifndef KEY_VALUE_MAP_WITH_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define KEY_VALUE_MAP_WITH_ID_ALLOCATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KVM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kvmap assertion failed");
// next-cycle implication
`define KVM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kvmap assertion failed");
`else
`define KVM_ASSERT_IMP(lbl, ante, cons)
`define KVM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* sv/kvmap_pkg.sv */
`timescale 1ns / 1ps

package kvmap_pkg;

  localparam int KEY_W     = 8;
  localparam int VAL_W     = 32;
  localparam int KEY_COUNT = 256;
  localparam int GRP_W     = 16;
  localparam int NUM_GRP   = KEY_COUNT / GRP_W;
  localparam int GRP_IDX_W = $clog2(GRP_W);
  localparam int GRP_SEL_W = $clog2(NUM_GRP);

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_ALLOC = 3'd1,
    OP_REM   = 3'd2,
    OP_LOOK  = 3'd3,
    OP_CLEAR = 3'd4
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } st_t;

endpackage

/* sv/key_value_map_with_id_allocator_unit.sv */
`timescale 1ns / 1ps
`include "key_value_map_with_id_allocator_unit_assert.svh"

// Channel  | Ports                                            | Handshake
// ---------+--------------------------------------------------+----------------------
// command  | in_operation, in_key, in_value                   | start && !busy
// result   | out_result_key, out_result_value, out_found,     | out_valid, one cycle,
//          | out_status                                       | no backpressure
//
// For each command, the accept cycle reads the value RAM and
// registers a per-group free scan of the bitmap; the execute cycle finishes the
// allocate search, updates bitmap/RAM and loads the result register.
// A new command can be accepted in the cycle its predecessor's result shows.
// Reset clears the valid bitmap at once (map empty); the value RAM is not reset.
// The receiver cannot stall; out_valid is a single-cycle strobe.
module key_value_map_with_id_allocator_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [2:0]                in_operation,
  input  logic [kvmap_pkg::KEY_W-1:0] in_key,
  input  logic [kvmap_pkg::VAL_W-1:0] in_value,
  output logic                      out_valid,
  output logic [kvmap_pkg::KEY_W-1:0] out_result_key,
  output logic [kvmap_pkg::VAL_W-1:0] out_result_value,
  output logic                      out_found,
  output logic                      out_status
);
  import kvmap_pkg::*;

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  st_t state_r, state_nxt;
  logic accept;
  logic exec;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Command capture (payload, no reset)
  logic [2:0]       op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_operation;
      key_r <= in_key;
      val_r <= in_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bitmap and first stage of the lowest-free search
  // ---------------------------------------------------------------------------
  logic [KEY_COUNT-1:0] inuse_r, inuse_nxt;
  logic [NUM_GRP-1:0]   grp_free, grp_free_r;
  logic [GRP_IDX_W-1:0] grp_low   [NUM_GRP];
  logic [GRP_IDX_W-1:0] grp_low_r [NUM_GRP];

  // per group: any free slot, and the lowest free slot
  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_free[g] = ~&inuse_r[g*GRP_W +: GRP_W];
      grp_low[g]  = '0;
      for (int b = GRP_W - 1; b >= 0; b--) begin
        if (!inuse_r[g*GRP_W + b]) grp_low[g] = GRP_IDX_W'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      grp_free_r <= grp_free;
      grp_low_r  <= grp_low;
    end
  end

  // second stage: pick the lowest group with room
  logic [GRP_SEL_W-1:0] alloc_grp;
  logic [KEY_W-1:0]     alloc_key;
  logic                 map_full;

  always_comb begin
    alloc_grp = '0;
    for (int g = NUM_GRP - 1; g >= 0; g--) begin
      if (grp_free_r[g]) alloc_grp = GRP_SEL_W'(g);
    end
  end

  assign alloc_key = {alloc_grp, grp_low_r[alloc_grp]};
  assign map_full  = ~|grp_free_r;

  // ---------------------------------------------------------------------------
  // Value RAM: read on accept, written in the execute cycle
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] mem [KEY_COUNT];
  logic [VAL_W-1:0] rd_data_r;
  logic             mem_we;
  logic [KEY_W-1:0] mem_waddr;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= val_r;
    if (accept) rd_data_r <= mem[in_key];
  end

  // ---------------------------------------------------------------------------
  // Execute: bitmap update and result
  // ---------------------------------------------------------------------------
  logic             in_range;
  logic             present;
  logic [KEY_W-1:0] res_key;
  logic [VAL_W-1:0] res_val;
  logic             res_found;
  logic             res_status;

  assign in_range = ({1'b0, key_r} < (KEY_W+1)'(KEY_COUNT));
  assign present  = in_range && inuse_r[key_r];

  always_comb begin
    inuse_nxt  = inuse_r;
    mem_we     = 1'b0;
    mem_waddr  = key_r;
    res_key    = '0;
    res_val    = '0;
    res_found  = 1'b0;
    res_status = 1'b0;
    if (exec) begin
      unique case (op_r)
        OP_ADD: begin
          res_key   = key_r;
          res_found = present;
          if (in_range) begin
            inuse_nxt[key_r] = 1'b1;
            mem_we           = 1'b1;
          end
        end
        OP_ALLOC: begin
          if (map_full) begin
            res_status = 1'b1;
          end else begin
            res_key              = alloc_key;
            inuse_nxt[alloc_key] = 1'b1;
            mem_we               = 1'b1;
            mem_waddr            = alloc_key;
          end
        end
        OP_REM: begin
          res_key   = key_r;
          res_found = present;
          if (present) inuse_nxt[key_r] = 1'b0;
        end
        OP_LOOK: begin
          res_key   = key_r;
          res_found = present;
          res_val   = present ? rd_data_r : '0;
        end
        OP_CLEAR: inuse_nxt = '0;
        default: ; // unused codes: no change, all-zero result
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) inuse_r <= '0;
    else        inuse_r <= inuse_nxt;
  end

  // Result register
  logic             out_valid_r;
  logic [KEY_W-1:0] out_key_r;
  logic [VAL_W-1:0] out_val_r;
  logic             out_found_r;
  logic             out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= exec;
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      out_key_r    <= res_key;
      out_val_r    <= res_val;
      out_found_r  <= res_found;
      out_status_r <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_key   = out_key_r;
  assign out_result_value = out_val_r;
  assign out_found        = out_found_r;
  assign out_status       = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `KVM_ASSERT_NXT(a_accept_exec, accept, busy && !out_valid)
  `KVM_ASSERT_NXT(a_exec_result, exec, out_valid && !busy)
  `KVM_ASSERT_IMP(a_full_result, out_valid && out_status,
                  out_result_key == '0 && !out_found && out_result_value == '0)
  `KVM_ASSERT_IMP(a_alloc_free, exec && op_r == OP_ALLOC && !map_full,
                  !inuse_r[alloc_key])

endmodule

/* verif/kvmap_tb_pkg.sv */
`timescale 1ns / 1ps

package kvmap_tb_pkg;
  import kvmap_pkg::*;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             found;
    logic             status;
  } map_result_t;

  // Shadow copy of the map plus the results it still owes.
  class map_result_tracker;
    bit               in_use [KEY_COUNT];
    logic [VAL_W-1:0] stored [KEY_COUNT];
    map_result_t      expected_q[$];
    int unsigned      mismatches;

    function new();
      foreach (in_use[i]) in_use[i] = 1'b0;
      mismatches = 0;
    endfunction

    // Update the shadow map for one accepted command and queue its result.
    function void apply_command(logic [2:0] op, logic [KEY_W-1:0] key,
                                logic [VAL_W-1:0] value);
      map_result_t r;
      int          free_key;
      bit          present;
      r        = '0;
      present  = in_use[key];
      free_key = -1;
      case (op)
        OP_ADD: begin
          in_use[key] = 1'b1;
          stored[key] = value;
          r.key       = key;
          r.found     = present;
        end
        OP_ALLOC: begin
          for (int k = KEY_COUNT - 1; k >= 0; k--)
            if (!in_use[k]) free_key = k;
          if (free_key < 0) begin
            r.status = 1'b1;
          end else begin
            in_use[free_key] = 1'b1;
            stored[free_key] = value;
            r.key            = free_key[KEY_W-1:0];
          end
        end
        OP_REM: begin
          in_use[key] = 1'b0;
          r.key       = key;
          r.found     = present;
        end
        OP_LOOK: begin
          r.key   = key;
          r.found = present;
          if (present) r.value = stored[key];
        end
        OP_CLEAR: begin
          foreach (in_use[i]) in_use[i] = 1'b0;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [KEY_W-1:0] key, logic [VAL_W-1:0] value,
                               logic found, logic status);
      map_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no command pending: key %0h value %0h", key, value);
        mismatches++;
        return;
      end
      e = expected_q.pop_front();
      if (key !== e.key) begin
        $error("result_key: expected %0h, got %0h", e.key, key);
        mismatches++;
      end
      if (value !== e.value) begin
        $error("result_value: expected %0h, got %0h", e.value, value);
        mismatches++;
      end
      if (found !== e.found) begin
        $error("found: expected %0b, got %0b", e.found, found);
        mismatches++;
      end
      if (status !== e.status) begin
        $error("status: expected %0b, got %0b", e.status, status);
        mismatches++;
      end
    endfunction
  endclass

endpackage

/* verif/tb_key_value_map_with_id_allocator_unit.sv */
`timescale 1ns / 1ps

module tb_key_value_map_with_id_allocator_unit;
  import kvmap_pkg::*;
  import kvmap_tb_pkg::*;

  // Opcodes outside the defined set; the block must answer them with all zeros.
  localparam logic [2:0] OP_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] OP_UNDEF_LAST  = 3'd7;

  localparam int TARGET_CMDS = 1150;
  // Cycles with neither a command nor a result transfer before giving up.
  // The longest idle gap that pick_gap gives is well below this limit.
  localparam int STALL_LIMIT = 2000;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [2:0]       in_operation;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic [KEY_W-1:0] out_result_key;
  logic [VAL_W-1:0] out_result_value;
  logic             out_found;
  logic             out_status;

  map_result_tracker tracker;
  int                cmds_sent;
  int                stall_cycles;

  key_value_map_with_id_allocator_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_key           (in_key),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_result_key   (out_result_key),
    .out_result_value (out_result_value),
    .out_found        (out_found),
    .out_status       (out_status)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results are strobes with no backpressure: every out_valid cycle is a transfer.
  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_result(out_result_key, out_result_value, out_found, out_status);
  end

  // Watchdog: only counts cycles where nothing moves on either channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one command from the falling edge and hold it until the rising
  // edge where busy is low. start stays high so back-to-back commands need
  // no gap; idle_gap lowers it.
  task automatic send_cmd(input logic [2:0] op, input logic [KEY_W-1:0] key,
                          input logic [VAL_W-1:0] value);
    @(negedge clk);
    start        = 1'b1;
    in_operation = op;
    in_key       = key;
    in_value     = value;
    do @(posedge clk); while (busy);
    tracker.apply_command(op, key, value);
    cmds_sent++;
  endtask

  task automatic idle_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      start        = 1'b0;
      in_operation = 3'($urandom());
      in_key       = KEY_W'($urandom());
      in_value     = $urandom();
    end
  endtask

  // Mostly back-to-back or short gaps, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 6);
    return $urandom_range(10, 40);
  endfunction

  // Bias toward all-zero and all-one data so every bit sees both values.
  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom();
  endfunction

  // Most keys come from a small window so adds, lookups and removes collide
  // with each other and with allocated ids; the rest span the whole key space.
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 75) return KEY_W'($urandom_range(0, 15));
    return KEY_W'($urandom_range(0, KEY_COUNT - 1));
  endfunction

  task automatic mixed_burst(input int len, input bit back_to_back);
    int         r;
    logic [2:0] op;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 28)      op = OP_ADD;
      else if (r < 43) op = OP_ALLOC;
      else if (r < 60) op = OP_REM;
      else if (r < 88) op = OP_LOOK;
      else if (r < 90) op = OP_CLEAR;
      else             op = 3'($urandom_range(OP_UNDEF_FIRST, OP_UNDEF_LAST));
      send_cmd(op, pick_key(), pick_value());
      if (!back_to_back) idle_gap(pick_gap());
    end
  endtask

  // Clear, allocate every id, run into the full condition, then free a few
  // ids and check that allocate reuses the lowest one.
  task automatic fill_burst();
    send_cmd(OP_CLEAR, KEY_W'($urandom()), $urandom());
    idle_gap(pick_gap());
    for (int i = 0; i < KEY_COUNT + 2; i++) begin
      send_cmd(OP_ALLOC, KEY_W'($urandom()), pick_value());
      if ($urandom_range(0, 3) == 0) idle_gap(pick_gap());
    end
    repeat (4) begin
      send_cmd(OP_LOOK, KEY_W'($urandom_range(0, KEY_COUNT - 1)), $urandom());
      idle_gap(pick_gap());
    end
    repeat (3) begin
      send_cmd(OP_REM, KEY_W'($urandom_range(0, KEY_COUNT - 1)), $urandom());
      idle_gap(pick_gap());
    end
    repeat (4) begin
      send_cmd(OP_ALLOC, KEY_W'($urandom()), pick_value());
      idle_gap(pick_gap());
    end
    // full map: overwrite and lookup still work
    send_cmd(OP_ADD, KEY_W'($urandom_range(0, KEY_COUNT - 1)), pick_value());
    send_cmd(OP_LOOK, KEY_W'($urandom_range(0, KEY_COUNT - 1)), $urandom());
  endtask

  initial begin
    tracker      = new();
    cmds_sent    = 0;
    stall_cycles = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = '0;
    in_key       = '0;
    in_value     = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty-map lookups, key/value extremes, overwrite, absent
    // remove, lowest-free reuse, undefined opcodes, clear.
    send_cmd(OP_CLEAR, 8'hFF, 32'hFFFF_FFFF);
    send_cmd(OP_LOOK,  8'h00, 32'h0);
    send_cmd(OP_ADD,   8'h00, 32'h0);
    idle_gap(1);
    send_cmd(OP_ADD,   8'hFF, 32'hFFFF_FFFF);
    send_cmd(OP_LOOK,  8'hFF, 32'h0);
    send_cmd(OP_ADD,   8'hFF, 32'h1234_5678);
    idle_gap(3);
    send_cmd(OP_LOOK,  8'hFF, 32'h0);
    send_cmd(OP_ALLOC, 8'hAA, 32'hA5A5_A5A5);
    send_cmd(OP_LOOK,  8'h01, 32'h0);
    send_cmd(OP_REM,   8'h00, 32'h0);
    idle_gap(2);
    send_cmd(OP_REM,   8'h00, 32'h0);
    send_cmd(OP_LOOK,  8'h00, 32'hFFFF_FFFF);
    send_cmd(OP_ALLOC, 8'h55, 32'h5A5A_5A5A);
    send_cmd(OP_LOOK,  8'h00, 32'h0);
    for (logic [2:0] op = OP_UNDEF_FIRST; op <= OP_UNDEF_LAST; op++) begin
      send_cmd(op, 8'hFF, 32'hFFFF_FFFF);
      if (op == OP_UNDEF_LAST) break;
    end
    send_cmd(OP_CLEAR, 8'h00, 32'h0);
    send_cmd(OP_LOOK,  8'hFF, 32'h0);
    send_cmd(OP_ALLOC, 8'h80, 32'h8000_0001);
    idle_gap(pick_gap());

    // Random: one or two full-map episodes, the rest mixed bursts, some of them
    // with no idle cycles at all.
    fill_burst();
    idle_gap(pick_gap());
    while (cmds_sent < TARGET_CMDS) begin
      mixed_burst($urandom_range(10, 60), $urandom_range(0, 9) == 0);
      idle_gap(pick_gap());
      if (cmds_sent > 700 && cmds_sent < 760) begin
        fill_burst();
        idle_gap(pick_gap());
      end
    end
    idle_gap(1);

    // Drain, then a short tail to catch stray strobes.
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
